>>> rtl/core/bsoc_pkg.sv
// ============================================================================
// bsoc_pkg
// Types and constants for the barometric second-order compensation pipeline.
// ============================================================================
package bsoc_pkg;

    // Field widths
    localparam int RAW_W   = 24;
    localparam int CAL_W   = 16;
    localparam int TEMP_W  = 19;
    localparam int PRESS_W = 32;

    // Calibration register indexes
    localparam int CAL_IDX_W = 3;
    localparam int NUM_CAL   = 6;

    typedef enum logic [CAL_IDX_W-1:0] {
        CAL_C1 = 3'd0,   // pressure sensitivity
        CAL_C2 = 3'd1,   // pressure offset
        CAL_C3 = 3'd2,   // temp coefficient of sensitivity
        CAL_C4 = 3'd3,   // temp coefficient of offset
        CAL_C5 = 3'd4,   // reference temperature
        CAL_C6 = 3'd5    // temp coefficient of temperature
    } t_cal_idx;

    // Band thresholds in 0.01 degC
    localparam logic signed [TEMP_W-1:0] TEMP_REF = 19'sd2000;
    localparam logic signed [TEMP_W-1:0] VLOW_REF = -19'sd1500;

    // Second-order coefficients
    localparam int OFF2_LOW_K   = 61;
    localparam int SENS2_LOW_K  = 29;
    localparam int OFF2_VLOW_K  = 17;
    localparam int SENS2_VLOW_K = 9;

    // Input item: one conversion pair
    typedef struct packed {
        logic [RAW_W-1:0] raw_pressure;
        logic [RAW_W-1:0] raw_temperature;
    } t_in_item;

    // Result item
    typedef struct packed {
        logic signed [TEMP_W-1:0]  temperature_centideg;
        logic signed [PRESS_W-1:0] pressure_centimbar;
    } t_out_item;

endpackage

>>> rtl/core/baro_second_order_compensation.sv
// ============================================================================
// baro_second_order_compensation
// Converts raw pressure/temperature conversions into compensated temperature
// (0.01 degC) and pressure (0.01 mbar) with second-order band corrections.
// ============================================================================
//
//  channel   signals                            direction
//  -------   --------------------------------   ---------------------------
//  input     i_valid / o_stall / i_in           conversion pair into block
//  output    o_valid / i_stall / o_out          compensated result out
//  config    i_cfg_we / i_cfg_idx / i_cfg_data  calibration word writes
//
//  Nine register stages; one transfer per cycle in and out while no result is stalled.
//  The widest step is the 24 x 41 pressure product, split into a 24 x 21 and
//  a 24 x 20 partial product in one stage and summed in the next.
//  A stall on a waiting result holds every stage at once; o_stall follows it
//  in the same cycle.
//  Reset clears the valid bits and the calibration words (to zero).
//
module baro_second_order_compensation (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input channel
    input  logic                              i_valid,
    output logic                              o_stall,
    input  bsoc_pkg::t_in_item                i_in,
    // output channel
    output logic                              o_valid,
    input  logic                              i_stall,
    output bsoc_pkg::t_out_item               o_out,
    // configuration
    input  logic                              i_cfg_we,
    input  logic [bsoc_pkg::CAL_IDX_W-1:0]    i_cfg_idx,
    input  logic [bsoc_pkg::CAL_W-1:0]        i_cfg_data
);

    import bsoc_pkg::*;

    localparam int NSTG = 9;

    // ------------------------------------------------------------------
    // Calibration words and pipeline control
    // ------------------------------------------------------------------
    logic [CAL_W-1:0] r_cal [NUM_CAL];
    logic [NSTG-1:0]  r_vld;
    logic             w_en;

    // Advance all stages unless the finished result is stalled
    assign w_en    = !(r_vld[NSTG-1] && i_stall);
    assign o_stall = !w_en;
    assign o_valid = r_vld[NSTG-1];

    // Write calibration words; ignore unknown indexes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_CAL; k++) begin
                r_cal[k] <= '0;
            end
        end else if (i_cfg_we && (i_cfg_idx <= CAL_C6)) begin
            r_cal[i_cfg_idx] <= i_cfg_data;
        end
    end

    // Shift valid bits along with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NSTG-2:0], i_valid};
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: dT = D2 - C5 * 256
    // ------------------------------------------------------------------
    logic [RAW_W-1:0]  r_s1_d1;
    logic signed [24:0] r_s1_dt;
    logic signed [24:0] n_s1_dt;

    assign n_s1_dt = $signed({1'b0, i_in.raw_temperature})
                   - $signed({1'b0, r_cal[CAL_C5], 8'h00});

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_d1 <= i_in.raw_pressure;
            r_s1_dt <= n_s1_dt;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: products of dT with C6, C4, C3 and with itself
    // ------------------------------------------------------------------
    logic [RAW_W-1:0]   r_s2_d1;
    logic signed [41:0] r_s2_p6, r_s2_p4, r_s2_p3;
    logic [47:0]        r_s2_dtsq;
    logic signed [41:0] n_s2_p6, n_s2_p4, n_s2_p3;
    logic signed [49:0] n_s2_dtsq;

    always_comb begin
        n_s2_p6   = r_s1_dt * $signed({1'b0, r_cal[CAL_C6]});
        n_s2_p4   = r_s1_dt * $signed({1'b0, r_cal[CAL_C4]});
        n_s2_p3   = r_s1_dt * $signed({1'b0, r_cal[CAL_C3]});
        n_s2_dtsq = r_s1_dt * r_s1_dt;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s2_d1   <= r_s1_d1;
            r_s2_p6   <= n_s2_p6;
            r_s2_p4   <= n_s2_p4;
            r_s2_p3   <= n_s2_p3;
            r_s2_dtsq <= n_s2_dtsq[47:0];
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: first-order TEMP, OFF, SENS; both T2 candidates
    // ------------------------------------------------------------------
    logic [RAW_W-1:0]          r_s3_d1;
    logic signed [TEMP_W-1:0]  r_s3_temp;
    logic signed [36:0]        r_s3_off;
    logic signed [35:0]        r_s3_sens;
    logic [12:0]               r_s3_t2h;
    logic [16:0]               r_s3_t2l;
    logic signed [41:0]        w_s3_p6_sh, w_s3_p4_sh, w_s3_p3_sh;
    logic [50:0]               w_s3_dtsq5;
    logic [49:0]               w_s3_dtsq3;
    logic signed [TEMP_W-1:0]  n_s3_temp;
    logic signed [36:0]        n_s3_off;
    logic signed [35:0]        n_s3_sens;

    always_comb begin
        w_s3_p6_sh = r_s2_p6 >>> 23;
        w_s3_p4_sh = r_s2_p4 >>> 6;
        w_s3_p3_sh = r_s2_p3 >>> 7;
        n_s3_temp  = TEMP_REF + $signed(w_s3_p6_sh[TEMP_W-1:0]);
        n_s3_off   = $signed({4'b0, r_cal[CAL_C2], 17'b0}) + $signed(w_s3_p4_sh[36:0]);
        n_s3_sens  = $signed({4'b0, r_cal[CAL_C1], 16'b0}) + $signed(w_s3_p3_sh[35:0]);
        // 5 * dT^2 and 3 * dT^2 as shift-add
        w_s3_dtsq5 = 51'({r_s2_dtsq, 2'b00}) + 51'(r_s2_dtsq);
        w_s3_dtsq3 = 50'({r_s2_dtsq, 1'b0}) + 50'(r_s2_dtsq);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s3_d1   <= r_s2_d1;
            r_s3_temp <= n_s3_temp;
            r_s3_off  <= n_s3_off;
            r_s3_sens <= n_s3_sens;
            r_s3_t2h  <= w_s3_dtsq5[50:38];
            r_s3_t2l  <= w_s3_dtsq3[49:33];
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: pick band, final temperature, squares of band distances
    // ------------------------------------------------------------------
    logic [RAW_W-1:0]          r_s4_d1;
    logic signed [TEMP_W-1:0]  r_s4_temp;
    logic signed [36:0]        r_s4_off;
    logic signed [35:0]        r_s4_sens;
    logic                      r_s4_high, r_s4_vlow;
    logic [34:0]               r_s4_asq, r_s4_bsq;
    logic                      n_s4_high, n_s4_vlow;
    logic [16:0]               w_s4_t2;
    logic signed [TEMP_W-1:0]  n_s4_temp;
    logic signed [19:0]        w_s4_a, w_s4_b;
    logic signed [39:0]        n_s4_asq, n_s4_bsq;

    always_comb begin
        // exactly 20.00 degC takes the high band
        n_s4_high = (r_s3_temp >= TEMP_REF);
        n_s4_vlow = (r_s3_temp < VLOW_REF);
        w_s4_t2   = n_s4_high ? {4'b0, r_s3_t2h} : r_s3_t2l;
        n_s4_temp = r_s3_temp - $signed({2'b0, w_s4_t2});
        w_s4_a    = $signed({r_s3_temp[TEMP_W-1], r_s3_temp})
                  - $signed({TEMP_REF[TEMP_W-1], TEMP_REF});
        w_s4_b    = $signed({r_s3_temp[TEMP_W-1], r_s3_temp})
                  - $signed({VLOW_REF[TEMP_W-1], VLOW_REF});
        n_s4_asq  = w_s4_a * w_s4_a;
        n_s4_bsq  = w_s4_b * w_s4_b;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s4_d1   <= r_s3_d1;
            r_s4_temp <= n_s4_temp;
            r_s4_off  <= r_s3_off;
            r_s4_sens <= r_s3_sens;
            r_s4_high <= n_s4_high;
            r_s4_vlow <= n_s4_vlow;
            r_s4_asq  <= n_s4_asq[34:0];
            r_s4_bsq  <= n_s4_bsq[34:0];
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: OFF2 and SENS2 from the band terms
    // ------------------------------------------------------------------
    logic [RAW_W-1:0]          r_s5_d1;
    logic signed [TEMP_W-1:0]  r_s5_temp;
    logic signed [36:0]        r_s5_off;
    logic signed [35:0]        r_s5_sens;
    logic [40:0]               r_s5_off2;
    logic [39:0]               r_s5_sens2;
    logic [40:0]               w_s5_off_lo, w_s5_off_vl, n_s5_off2;
    logic [39:0]               w_s5_sens_lo, w_s5_sens_vl, n_s5_sens2;

    always_comb begin
        w_s5_off_lo  = (41'(r_s4_asq) * 41'(OFF2_LOW_K)) >> 4;
        w_s5_off_vl  = 41'(r_s4_bsq) * 41'(OFF2_VLOW_K);
        w_s5_sens_lo = (40'(r_s4_asq) * 40'(SENS2_LOW_K)) >> 4;
        w_s5_sens_vl = 40'(r_s4_bsq) * 40'(SENS2_VLOW_K);
        if (r_s4_high) begin
            n_s5_off2  = '0;
            n_s5_sens2 = '0;
        end else if (r_s4_vlow) begin
            n_s5_off2  = w_s5_off_lo + w_s5_off_vl;
            n_s5_sens2 = w_s5_sens_lo + w_s5_sens_vl;
        end else begin
            n_s5_off2  = w_s5_off_lo;
            n_s5_sens2 = w_s5_sens_lo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s5_d1    <= r_s4_d1;
            r_s5_temp  <= r_s4_temp;
            r_s5_off   <= r_s4_off;
            r_s5_sens  <= r_s4_sens;
            r_s5_off2  <= n_s5_off2;
            r_s5_sens2 <= n_s5_sens2;
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: net offset and sensitivity
    // ------------------------------------------------------------------
    logic [RAW_W-1:0]          r_s6_d1;
    logic signed [TEMP_W-1:0]  r_s6_temp;
    logic signed [41:0]        r_s6_off_net;
    logic signed [40:0]        r_s6_sens_net;
    logic signed [41:0]        n_s6_off_net;
    logic signed [40:0]        n_s6_sens_net;

    always_comb begin
        n_s6_off_net  = $signed({{5{r_s5_off[36]}}, r_s5_off}) - $signed({1'b0, r_s5_off2});
        n_s6_sens_net = $signed({{5{r_s5_sens[35]}}, r_s5_sens})
                      - $signed({1'b0, r_s5_sens2});
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s6_d1       <= r_s5_d1;
            r_s6_temp     <= r_s5_temp;
            r_s6_off_net  <= n_s6_off_net;
            r_s6_sens_net <= n_s6_sens_net;
        end
    end

    // ------------------------------------------------------------------
    // Stage 7: D1 * SENS as two partial products
    // ------------------------------------------------------------------
    logic signed [TEMP_W-1:0]  r_s7_temp;
    logic signed [41:0]        r_s7_off_net;
    logic [44:0]               r_s7_pp_lo;
    logic signed [44:0]        r_s7_pp_hi;
    logic [20:0]               w_s7_lo;
    logic signed [19:0]        w_s7_hi;
    logic [44:0]               n_s7_pp_lo;
    logic signed [44:0]        n_s7_pp_hi;

    always_comb begin
        w_s7_lo    = r_s6_sens_net[20:0];
        w_s7_hi    = r_s6_sens_net[40:21];
        n_s7_pp_lo = 45'(r_s6_d1) * 45'(w_s7_lo);
        n_s7_pp_hi = $signed({1'b0, r_s6_d1}) * w_s7_hi;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s7_temp    <= r_s6_temp;
            r_s7_off_net <= r_s6_off_net;
            r_s7_pp_lo   <= n_s7_pp_lo;
            r_s7_pp_hi   <= n_s7_pp_hi;
        end
    end

    // ------------------------------------------------------------------
    // Stage 8: sum the partial products
    // ------------------------------------------------------------------
    logic signed [TEMP_W-1:0]  r_s8_temp;
    logic signed [41:0]        r_s8_off_net;
    logic signed [65:0]        r_s8_prod;
    logic signed [65:0]        n_s8_prod;

    assign n_s8_prod = $signed({r_s7_pp_hi, 21'b0}) + $signed({21'b0, r_s7_pp_lo});

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s8_temp    <= r_s7_temp;
            r_s8_off_net <= r_s7_off_net;
            r_s8_prod    <= n_s8_prod;
        end
    end

    // ------------------------------------------------------------------
    // Stage 9: P = ((D1 * SENS >> 21) - OFF) >> 15 into the output register
    // ------------------------------------------------------------------
    // The operand ranges keep P inside 31 bits, so no 32-bit clamp is needed
    // and the result is the low PRESS_W bits of the difference, taken as they are.
    t_out_item          r_out;
    t_out_item          n_out;
    logic signed [65:0] w_s9_prod_sh;
    logic signed [45:0] w_s9_diff;
    logic signed [45:0] w_s9_p;

    always_comb begin
        w_s9_prod_sh = r_s8_prod >>> 21;
        w_s9_diff    = $signed(w_s9_prod_sh[45:0])
                     - $signed({{4{r_s8_off_net[41]}}, r_s8_off_net});
        w_s9_p       = w_s9_diff >>> 15;
        n_out.temperature_centideg = r_s8_temp;
        n_out.pressure_centimbar   = w_s9_p[PRESS_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out <= n_out;
        end
    end

    assign o_out = r_out;

endmodule

>>> sim/baro_second_order_compensation_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// baro_second_order_compensation_tb
// Drives raw pressure/temperature conversion pairs through the compensation
// pipeline under several calibration sets. An independent integer model
// predicts each compensated reading. A scoreboard checks the results in order,
// with random idling on both channels and one long output hold-off.
// ============================================================================
module baro_second_order_compensation_tb;
    import bsoc_pkg::*;

    localparam int CLK_PERIOD      = 10;
    localparam int IDLE_PCT        = 22;
    localparam int HOLD_CYCLES     = 200;
    localparam int DRAIN_CYCLES    = 14;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int RAND_PHASES     = 8;
    localparam int ITEMS_PER_PHASE = 116;
    localparam int NEAR_SPAN       = 65536;
    localparam int WIDE_SPAN       = 1 << 22;

    localparam logic [CAL_IDX_W-1:0] CAL_IDX_UNUSED_LO = 3'd6;
    localparam logic [CAL_IDX_W-1:0] CAL_IDX_UNUSED_HI = 3'd7;

    localparam longint            PRESS_MAX = 64'sh0000_0000_7FFF_FFFF;
    localparam longint            PRESS_MIN = -64'sh0000_0000_8000_0000;
    localparam longint            RAW_MAX   = (64'sd1 << RAW_W) - 1;
    localparam logic [RAW_W-1:0]  TYP_D1    = 24'd6465444;

    // ------------------------------------------------------------------------
    // Scoreboard: calibration copy, reading prediction and in-order check
    // ------------------------------------------------------------------------
    class baro_scoreboard;
        logic [CAL_W-1:0] cal_word [NUM_CAL];
        t_out_item        pending_readings [$];
        int               mismatches;

        function new();
            foreach (cal_word[i]) cal_word[i] = '0;
            mismatches = 0;
        endfunction

        // Writes to unused indexes are dropped by the block
        function void set_cal(logic [CAL_IDX_W-1:0] idx, logic [CAL_W-1:0] val);
            if (idx < NUM_CAL) cal_word[idx] = val;
        endfunction

        function int pending();
            return pending_readings.size();
        endfunction

        function t_out_item compensate(t_in_item conv);
            longint    d1, d2, c1, c2, c3, c4, c5, c6;
            longint    dt, tc, off, sens, t2, off2, sens2, a, b, p;
            t_out_item r;
            d1 = conv.raw_pressure;
            d2 = conv.raw_temperature;
            c1 = cal_word[CAL_C1];
            c2 = cal_word[CAL_C2];
            c3 = cal_word[CAL_C3];
            c4 = cal_word[CAL_C4];
            c5 = cal_word[CAL_C5];
            c6 = cal_word[CAL_C6];

            // first-order terms; >>> on signed values floors like the sensor math
            dt   = d2 - c5 * 256;
            tc   = longint'(TEMP_REF) + ((dt * c6) >>> 23);
            off  = c2 * 131072 + ((c4 * dt) >>> 6);
            sens = c1 * 65536 + ((c3 * dt) >>> 7);

            // second-order bands; exactly 20.00 degC takes the high-band rule
            if (tc >= longint'(TEMP_REF)) begin
                t2    = (5 * dt * dt) >>> 38;
                off2  = 0;
                sens2 = 0;
            end else begin
                a     = tc - longint'(TEMP_REF);
                t2    = (3 * dt * dt) >>> 33;
                off2  = (OFF2_LOW_K * a * a) >>> 4;
                sens2 = (SENS2_LOW_K * a * a) >>> 4;
                if (tc < longint'(VLOW_REF)) begin
                    b     = tc - longint'(VLOW_REF);
                    off2  = off2 + OFF2_VLOW_K * b * b;
                    sens2 = sens2 + SENS2_VLOW_K * b * b;
                end
            end

            tc   = tc - t2;
            off  = off - off2;
            sens = sens - sens2;

            // pressure, clamped to the signed 32-bit range
            p = (((d1 * sens) >>> 21) - off) >>> 15;
            if (p > PRESS_MAX) p = PRESS_MAX;
            if (p < PRESS_MIN) p = PRESS_MIN;

            r.temperature_centideg = tc[TEMP_W-1:0];
            r.pressure_centimbar   = p[PRESS_W-1:0];
            return r;
        endfunction

        function void note_conversion(t_in_item conv);
            pending_readings.push_back(compensate(conv));
        endfunction

        function void check_reading(t_out_item got);
            t_out_item want;
            if (pending_readings.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected reading: expected none, actual temp %0d press %0d",
                         $time, got.temperature_centideg, got.pressure_centimbar);
                return;
            end
            want = pending_readings.pop_front();
            if (got.temperature_centideg !== want.temperature_centideg) begin
                mismatches++;
                $display("%0t: temperature mismatch: expected %0d, actual %0d",
                         $time, want.temperature_centideg, got.temperature_centideg);
            end
            if (got.pressure_centimbar !== want.pressure_centimbar) begin
                mismatches++;
                $display("%0t: pressure mismatch: expected %0d, actual %0d",
                         $time, want.pressure_centimbar, got.pressure_centimbar);
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT signals and instance
    // ------------------------------------------------------------------------
    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_stall;
    t_in_item             i_in;
    logic                 o_valid;
    logic                 i_stall;
    t_out_item            o_out;
    logic                 i_cfg_we;
    logic [CAL_IDX_W-1:0] i_cfg_idx;
    logic [CAL_W-1:0]     i_cfg_data;

    baro_second_order_compensation dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_in       (i_in),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_out      (o_out),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    baro_scoreboard   sb;
    logic [CAL_W-1:0] cal_plan [NUM_CAL];
    bit               no_idle  = 1'b0;
    bit               hold_req = 1'b0;
    int               idle_cycles = 0;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Monitor both channels at the rising edge; watchdog on stuck transfers
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) sb.note_conversion(i_in);
            if (o_valid && !i_stall) sb.check_reading(o_out);
        end
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || i_cfg_we)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL baro_second_order_compensation");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: random stalls, one long hold-off on request
    // ------------------------------------------------------------------------
    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
            end
            i_stall <= !no_idle && ($urandom_range(99) < IDLE_PCT);
        end
    end

    function automatic t_in_item conversion_pair(logic [RAW_W-1:0] d1,
                                                 logic [RAW_W-1:0] d2);
        t_in_item conv;
        conv.raw_pressure    = d1;
        conv.raw_temperature = d2;
        return conv;
    endfunction

    // Raw temperature at a signed distance from the reference reading, clamped
    function automatic logic [RAW_W-1:0] near_reference(longint ref_pt, longint delta);
        longint d2;
        d2 = ref_pt + delta;
        if (d2 < 0) d2 = 0;
        if (d2 > RAW_MAX) d2 = RAW_MAX;
        return d2[RAW_W-1:0];
    endfunction

    // Offer one pair with a random gap first; return at the falling edge after its transfer
    task automatic send_item(input t_in_item conv);
        while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in    <= conv;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
    endtask

    // Drop valid, wait for every reading, then let the pipeline settle
    task automatic wait_drained();
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Load cal_plan into the block while idle, plus one write to an unused index
    task automatic program_cals();
        logic [CAL_IDX_W-1:0] bad_idx;
        logic [CAL_W-1:0]     bad_data;
        wait_drained();
        for (int i = 0; i < NUM_CAL; i++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= t_cal_idx'(i);
            i_cfg_data <= cal_plan[i];
            @(posedge i_clk);
            sb.set_cal(t_cal_idx'(i), cal_plan[i]);
            @(negedge i_clk);
        end
        bad_idx  = CAL_IDX_W'($urandom_range(CAL_IDX_UNUSED_HI, CAL_IDX_UNUSED_LO));
        bad_data = CAL_W'($urandom);
        i_cfg_idx  <= bad_idx;
        i_cfg_data <= bad_data;
        @(posedge i_clk);
        sb.set_cal(bad_idx, bad_data);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        int unsigned      phase, n;
        int               spread;
        logic [RAW_W-1:0] d1, d2;
        longint           ref_pt;

        sb         = new();
        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_in       = '0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = '0;
        i_cfg_data = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // calibration still at reset (all zero): raw field extremes
        send_item(conversion_pair('0, '0));
        send_item(conversion_pair('1, '1));
        send_item(conversion_pair('1, '0));
        send_item(conversion_pair('0, '1));

        // C6 = 2^13 makes TEMP = 2000 + (dT >> 10), so band edges fall on known dT
        cal_plan[CAL_C1] = 16'd46372;
        cal_plan[CAL_C2] = 16'd43981;
        cal_plan[CAL_C3] = 16'd29059;
        cal_plan[CAL_C4] = 16'd27842;
        cal_plan[CAL_C5] = 16'd32768;
        cal_plan[CAL_C6] = 16'd8192;
        program_cals();
        ref_pt = cal_plan[CAL_C5];
        ref_pt = ref_pt * 256;
        send_item(conversion_pair(TYP_D1, near_reference(ref_pt, 0)));
        send_item(conversion_pair(TYP_D1, near_reference(ref_pt, 1023)));
        send_item(conversion_pair(TYP_D1, near_reference(ref_pt, 1024)));
        // just below 20.00 degC
        send_item(conversion_pair(TYP_D1, near_reference(ref_pt, -1)));
        send_item(conversion_pair(TYP_D1, near_reference(ref_pt, -1024)));
        send_item(conversion_pair(TYP_D1, near_reference(ref_pt, -500000)));
        // exactly -15.00 degC, then one step into the very-low band
        send_item(conversion_pair(TYP_D1, near_reference(ref_pt, -3584000)));
        send_item(conversion_pair(TYP_D1, near_reference(ref_pt, -3584001)));
        send_item(conversion_pair(TYP_D1, near_reference(ref_pt, -8388608)));
        send_item(conversion_pair(TYP_D1, near_reference(ref_pt, 8388607)));
        send_item(conversion_pair('0, near_reference(ref_pt, 0)));
        send_item(conversion_pair('1, near_reference(ref_pt, 0)));

        // all calibration words at maximum
        foreach (cal_plan[i]) cal_plan[i] = '1;
        program_cals();
        send_item(conversion_pair('0, '0));
        send_item(conversion_pair('1, '0));
        send_item(conversion_pair('1, '1));
        send_item(conversion_pair(24'h800000, 24'd16776960));

        // random phases, each under its own calibration set
        for (phase = 0; phase < RAND_PHASES; phase++) begin
            case (phase)
                0: foreach (cal_plan[i]) cal_plan[i] = '1;
                1: foreach (cal_plan[i]) cal_plan[i] = '0;
                default: foreach (cal_plan[i]) cal_plan[i] = CAL_W'($urandom);
            endcase
            program_cals();
            ref_pt = cal_plan[CAL_C5];
            ref_pt = ref_pt * 256;
            no_idle = (phase == 3);
            if (phase == 5) hold_req = 1'b1;

            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                d1 = RAW_W'($urandom);
                if ($urandom_range(15) == 0) d1 = $urandom_range(1) ? '1 : '0;
                // half full-range, half clustered around the reference reading
                case ($urandom_range(3))
                    0, 1: d2 = RAW_W'($urandom);
                    2: begin
                        spread = int'($urandom_range(2 * NEAR_SPAN)) - NEAR_SPAN;
                        d2     = near_reference(ref_pt, spread);
                    end
                    default: begin
                        spread = int'($urandom_range(2 * WIDE_SPAN)) - WIDE_SPAN;
                        d2     = near_reference(ref_pt, spread);
                    end
                endcase
                send_item(conversion_pair(d1, d2));
            end
            no_idle = 1'b0;
        end

        wait_drained();
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("PASS baro_second_order_compensation");
        else
            $display("FAIL baro_second_order_compensation");
        $finish;
    end

endmodule

>>> sim.f
rtl/core/bsoc_pkg.sv
rtl/core/baro_second_order_compensation.sv
sim/baro_second_order_compensation_tb.sv
